>>> rtl/rls_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rls_pkg
// Shared types, codes and helpers of the reader link supervisor.
// ----------------------------------------------------------------------------
package rls_pkg;

    // event codes
    localparam logic [2:0] FN_TICK     = 3'd0;
    localparam logic [2:0] FN_START    = 3'd1;
    localparam logic [2:0] FN_FRAME    = 3'd2;
    localparam logic [2:0] FN_CSUM_ERR = 3'd3;
    localparam logic [2:0] FN_FRM_ERR  = 3'd4;
    localparam logic [2:0] FN_OVERFLOW = 3'd5;
    localparam logic [2:0] FN_IO_ERR   = 3'd6;
    localparam logic [2:0] FN_BYTES    = 3'd7;

    // frame kinds
    localparam logic [1:0] FK_CARD     = 2'd0;
    localparam logic [1:0] FK_MODE     = 2'd1;
    localparam logic [1:0] FK_BEHAVIOR = 2'd2;
    localparam logic [1:0] FK_OTHER    = 2'd3;

    // link status
    localparam logic [2:0] LS_UNSTARTED = 3'd0;
    localparam logic [2:0] LS_INIT      = 3'd1;
    localparam logic [2:0] LS_VERIFY    = 3'd2;
    localparam logic [2:0] LS_READY     = 3'd3;
    localparam logic [2:0] LS_MISMATCH  = 3'd4;
    localparam logic [2:0] LS_TIMEOUT   = 3'd5;
    localparam logic [2:0] LS_IOERR     = 3'd6;

    // config register indexes
    localparam logic [2:0] CR_ADDRESS  = 3'd0;
    localparam logic [2:0] CR_SETTLE   = 3'd1;
    localparam logic [2:0] CR_REPLY_TO = 3'd2;
    localparam logic [2:0] CR_GAP      = 3'd3;
    localparam logic [2:0] CR_HEALTH   = 3'd4;
    localparam logic [2:0] CR_RECOVERY = 3'd5;
    localparam logic [2:0] CR_LIMIT    = 3'd6;

    localparam logic [15:0] RST_SETTLE   = 16'd1000;
    localparam logic [15:0] RST_REPLY_TO = 16'd300;
    localparam logic [15:0] RST_GAP      = 16'd120;
    localparam logic [15:0] RST_HEALTH   = 16'd2000;
    localparam logic [15:0] RST_RECOVERY = 16'd1000;
    localparam logic [3:0]  RST_LIMIT    = 4'd3;

    localparam logic [7:0] WANT_MODE     = 8'h02;
    localparam logic [7:0] WANT_UPLOAD   = 8'h00;
    localparam logic [7:0] WANT_BEHAVIOR = 8'h00;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] now;
        logic [1:0]  frame_kind;
        logic        decode_ok;
        logic [7:0]  mode_value;
        logic [7:0]  upload_value;
        logic [7:0]  card_kind;
        logic [31:0] card_id;
    } t_in_word;

    typedef struct packed {
        logic [31:0] timeout_count;
        logic [31:0] checksum_count;
        logic [31:0] bad_frame_count;
        logic [31:0] overflow_count;
        logic [31:0] card_events;
        logic [7:0]  latest_card_kind;
        logic [31:0] latest_card_id;
        logic [31:0] latest_card_tick;
        logic [31:0] latest_rx_tick;
    } t_stat_word;

    typedef struct packed {
        logic        send_valid;
        logic        send_which;
        logic [2:0]  link_status;
        logic [31:0] timeout_count;
        logic [31:0] checksum_count;
        logic [31:0] bad_frame_count;
        logic [31:0] overflow_count;
        logic [31:0] card_events;
        logic [7:0]  latest_card_kind;
        logic [31:0] latest_card_id;
        logic [31:0] latest_card_tick;
        logic [31:0] latest_rx_tick;
    } t_out_word;

    typedef struct packed {
        logic [2:0]  index;
        logic [15:0] value;
    } t_cfg_word;

    typedef struct packed {
        logic [15:0] settle;
        logic [15:0] reply_to;
        logic [15:0] gap;
        logic [15:0] health;
        logic [15:0] recovery;
        logic [3:0]  limit;
    } t_cfg_regs;

    typedef struct packed {
        logic inc_timeout;
        logic inc_bad;
        logic take_card;
    } t_stat_evt;

    typedef struct packed {
        logic       send_valid;
        logic       send_which;
        logic [2:0] link_status;
    } t_ctrl_res;

    // wrap-safe: now has reached when
    function automatic logic is_due(input logic [31:0] now, input logic [31:0] when);
        logic [31:0] diff;
        diff = now - when;
        return ~diff[31];
    endfunction

endpackage
`default_nettype wire

>>> rtl/rls_chan_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rls_chan_if
// Valid/ready channel carrying one word of type T.
// ----------------------------------------------------------------------------
interface rls_chan_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/rls_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rls_ctrl
// Link phase sequencer: settle, mode and behavior verification, retries,
// recovery and health checks. One event per enabled cycle.
// ----------------------------------------------------------------------------
module rls_ctrl
    import rls_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_en,
    input  wire t_in_word  i_item,
    input  wire t_cfg_regs i_cfg,
    output t_ctrl_res      o_res,
    output t_stat_evt      o_evt
);

    localparam logic [3:0] PH_IDLE        = 4'd0;
    localparam logic [3:0] PH_SETTLE      = 4'd1;
    localparam logic [3:0] PH_B1_DUE      = 4'd2;
    localparam logic [3:0] PH_B1_WAIT     = 4'd3;
    localparam logic [3:0] PH_B8_DUE      = 4'd4;
    localparam logic [3:0] PH_B8_WAIT     = 4'd5;
    localparam logic [3:0] PH_HEALTH_DUE  = 4'd6;
    localparam logic [3:0] PH_HEALTH_WAIT = 4'd7;
    localparam logic [3:0] PH_READY       = 4'd8;
    localparam logic [3:0] PH_RECOVERY    = 4'd9;
    localparam logic [3:0] PH_STOPPED     = 4'd10;

    logic [3:0]  r_phase,    n_phase;
    logic [2:0]  r_link,     n_link;
    logic [3:0]  r_attempt,  n_attempt;
    logic [31:0] r_next,     n_next;
    logic [31:0] r_deadline, n_deadline;
    logic        r_pend_beh, n_pend_beh;
    logic        r_pend_hlt, n_pend_hlt;

    logic [31:0] now;
    logic [31:0] tick_gap, tick_recov, tick_health, tick_settle, tick_reply;
    logic [3:0]  fail_phase;
    logic [2:0]  fail_link;
    logic [31:0] fail_next;
    logic        fail_due;
    logic        due_next;
    logic        waiting;
    logic        send;
    logic        which;

    assign now         = i_item.now;
    assign tick_gap    = now + {16'd0, i_cfg.gap};
    assign tick_recov  = now + {16'd0, i_cfg.recovery};
    assign tick_health = now + {16'd0, i_cfg.health};
    assign tick_settle = now + {16'd0, i_cfg.settle};
    assign tick_reply  = now + {16'd0, i_cfg.reply_to};

    // outcome of a failed attempt
    always_comb begin
        if (r_attempt < i_cfg.limit) begin
            fail_link = r_link;
            fail_next = tick_gap;
            fail_due  = (i_cfg.gap == 16'd0);
            if (r_pend_beh) begin
                fail_phase = PH_B8_DUE;
            end else if (r_pend_hlt) begin
                fail_phase = PH_HEALTH_DUE;
            end else begin
                fail_phase = PH_B1_DUE;
            end
        end else begin
            fail_link  = LS_TIMEOUT;
            fail_phase = PH_RECOVERY;
            fail_next  = tick_recov;
            fail_due   = (i_cfg.recovery == 16'd0);
        end
    end

    assign waiting = (r_phase == PH_B1_WAIT) || (r_phase == PH_B8_WAIT) ||
                     (r_phase == PH_HEALTH_WAIT);

    always_comb begin
        n_phase    = r_phase;
        n_link     = r_link;
        n_attempt  = r_attempt;
        n_next     = r_next;
        n_deadline = r_deadline;
        n_pend_beh = r_pend_beh;
        n_pend_hlt = r_pend_hlt;
        send       = 1'b0;
        which      = 1'b0;
        due_next   = is_due(now, r_next);
        o_evt      = '0;

        case (i_item.func)
            FN_TICK: begin
                if (waiting && is_due(now, r_deadline)) begin
                    o_evt.inc_timeout = 1'b1;
                    n_phase  = fail_phase;
                    n_link   = fail_link;
                    n_next   = fail_next;
                    due_next = fail_due;
                end
                if ((n_phase == PH_SETTLE || n_phase == PH_RECOVERY) && due_next) begin
                    n_link    = LS_VERIFY;
                    n_attempt = 4'd0;
                    n_phase   = PH_B1_DUE;
                end else if (n_phase == PH_READY && due_next) begin
                    n_attempt  = 4'd1;
                    n_pend_beh = 1'b0;
                    n_pend_hlt = 1'b1;
                    n_deadline = tick_reply;
                    n_phase    = PH_HEALTH_WAIT;
                    send       = 1'b1;
                end
                if (!send && due_next) begin
                    case (n_phase)
                        PH_B1_DUE: begin
                            n_pend_beh = 1'b0;
                            n_pend_hlt = 1'b0;
                            n_attempt  = n_attempt + 4'd1;
                            n_deadline = tick_reply;
                            n_phase    = PH_B1_WAIT;
                            send       = 1'b1;
                        end
                        PH_B8_DUE: begin
                            n_pend_beh = 1'b1;
                            n_pend_hlt = 1'b0;
                            n_attempt  = n_attempt + 4'd1;
                            n_deadline = tick_reply;
                            n_phase    = PH_B8_WAIT;
                            send       = 1'b1;
                            which      = 1'b1;
                        end
                        PH_HEALTH_DUE: begin
                            n_pend_beh = 1'b0;
                            n_pend_hlt = 1'b1;
                            n_attempt  = n_attempt + 4'd1;
                            n_deadline = tick_reply;
                            n_phase    = PH_HEALTH_WAIT;
                            send       = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            FN_START: begin
                n_link    = LS_INIT;
                n_phase   = PH_SETTLE;
                n_next    = tick_settle;
                n_attempt = 4'd0;
            end
            FN_FRAME: begin
                if (i_item.frame_kind == FK_CARD && i_item.decode_ok) begin
                    o_evt.take_card = (r_link == LS_READY);
                end else if (i_item.frame_kind == FK_MODE &&
                             (r_phase == PH_B1_WAIT || r_phase == PH_HEALTH_WAIT)) begin
                    if (!i_item.decode_ok) begin
                        o_evt.inc_bad = 1'b1;
                        n_phase = fail_phase;
                        n_link  = fail_link;
                        n_next  = fail_next;
                    end else if (i_item.mode_value != WANT_MODE ||
                                 i_item.upload_value != WANT_UPLOAD) begin
                        n_link  = LS_MISMATCH;
                        n_phase = PH_STOPPED;
                    end else if (r_phase == PH_HEALTH_WAIT) begin
                        n_link    = LS_READY;
                        n_phase   = PH_READY;
                        n_attempt = 4'd0;
                        n_next    = tick_health;
                    end else begin
                        n_attempt = 4'd0;
                        n_phase   = PH_B8_DUE;
                        n_next    = tick_gap;
                    end
                end else if (i_item.frame_kind == FK_BEHAVIOR && r_phase == PH_B8_WAIT) begin
                    if (!i_item.decode_ok) begin
                        o_evt.inc_bad = 1'b1;
                        n_phase = fail_phase;
                        n_link  = fail_link;
                        n_next  = fail_next;
                    end else if (i_item.mode_value != WANT_BEHAVIOR) begin
                        n_link  = LS_MISMATCH;
                        n_phase = PH_STOPPED;
                    end else begin
                        n_link    = LS_READY;
                        n_phase   = PH_READY;
                        n_attempt = 4'd0;
                        n_next    = tick_health;
                    end
                end else begin
                    o_evt.inc_bad = 1'b1;
                end
            end
            FN_FRM_ERR: begin
                o_evt.inc_bad = 1'b1;
            end
            FN_IO_ERR: begin
                n_link  = LS_IOERR;
                n_phase = PH_STOPPED;
            end
            default: begin
            end
        endcase

        o_res.send_valid  = send;
        o_res.send_which  = which;
        o_res.link_status = n_link;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_link     <= LS_UNSTARTED;
            r_attempt  <= 4'd0;
            r_next     <= 32'd0;
            r_deadline <= 32'd0;
            r_pend_beh <= 1'b0;
            r_pend_hlt <= 1'b0;
        end else if (i_en) begin
            r_phase    <= n_phase;
            r_link     <= n_link;
            r_attempt  <= n_attempt;
            r_next     <= n_next;
            r_deadline <= n_deadline;
            r_pend_beh <= n_pend_beh;
            r_pend_hlt <= n_pend_hlt;
        end
    end

endmodule
`default_nettype wire

>>> rtl/rls_stats.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rls_stats
// Wrapping error counters, card record and receive time stamp.
// ----------------------------------------------------------------------------
module rls_stats
    import rls_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_en,
    input  wire t_in_word  i_item,
    input  wire t_stat_evt i_evt,
    output t_stat_word     o_next
);

    t_stat_word r_stat, n_stat;

    always_comb begin
        n_stat = r_stat;
        if (i_item.func == FN_START) begin
            n_stat = '0;
        end else begin
            if (i_evt.inc_timeout) begin
                n_stat.timeout_count = r_stat.timeout_count + 32'd1;
            end
            if (i_evt.inc_bad) begin
                n_stat.bad_frame_count = r_stat.bad_frame_count + 32'd1;
            end
            if (i_item.func == FN_CSUM_ERR) begin
                n_stat.checksum_count = r_stat.checksum_count + 32'd1;
            end
            if (i_item.func == FN_OVERFLOW) begin
                n_stat.overflow_count = r_stat.overflow_count + 32'd1;
            end
            if (i_evt.take_card) begin
                n_stat.card_events      = r_stat.card_events + 32'd1;
                n_stat.latest_card_kind = i_item.card_kind;
                n_stat.latest_card_id   = i_item.card_id;
                n_stat.latest_card_tick = i_item.now;
            end
            if (i_item.func == FN_FRAME || i_item.func == FN_CSUM_ERR ||
                i_item.func == FN_FRM_ERR || i_item.func == FN_BYTES) begin
                n_stat.latest_rx_tick = i_item.now;
            end
        end
    end

    assign o_next = n_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stat <= '0;
        end else if (i_en) begin
            r_stat <= n_stat;
        end
    end

endmodule
`default_nettype wire

>>> rtl/reader_link_supervisor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// reader_link_supervisor
// Card-reader link supervisor: takes one event word per cycle unless the output
// stalls; returns the query to send and a snapshot of link status, counters, card record.
// ----------------------------------------------------------------------------
//  port    dir  word         role
//  i_in    in   t_in_word    events (tick, start, frame, errors)
//  o_out   out  t_out_word   query request and link snapshot
//  i_cfg   in   t_cfg_word   register writes, always ready
//
//  One event per cycle while the output is not stalled.
//  Event register feeds the sequencer and counters, whose result is
//  captured in the output register while their state updates.
//  A stalled output holds the event register; input ready then drops.
//  Reset (synchronous, active low) restores register defaults and clears state.
module reader_link_supervisor
    import rls_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rls_chan_if.sink   i_in,
    rls_chan_if.source o_out,
    rls_chan_if.sink   i_cfg
);

    t_in_word   r_item;
    logic       r_item_vld;
    t_out_word  r_out, n_out;
    logic       r_out_vld;
    t_cfg_regs  r_cfg;
    logic       advance;
    t_ctrl_res  ctrl_res;
    t_stat_evt  stat_evt;
    t_stat_word stat_next;

    assign advance     = r_item_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready  = !r_item_vld || advance;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    // address check is already folded into decode_ok; that write is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.settle   <= RST_SETTLE;
            r_cfg.reply_to <= RST_REPLY_TO;
            r_cfg.gap      <= RST_GAP;
            r_cfg.health   <= RST_HEALTH;
            r_cfg.recovery <= RST_RECOVERY;
            r_cfg.limit    <= RST_LIMIT;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                CR_SETTLE:   r_cfg.settle   <= i_cfg.data.value;
                CR_REPLY_TO: r_cfg.reply_to <= i_cfg.data.value;
                CR_GAP:      r_cfg.gap      <= i_cfg.data.value;
                CR_HEALTH:   r_cfg.health   <= i_cfg.data.value;
                CR_RECOVERY: r_cfg.recovery <= i_cfg.data.value;
                CR_LIMIT:    r_cfg.limit    <= i_cfg.data.value[3:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_item_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item <= i_in.data;
        end
    end

    rls_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_item  (r_item),
        .i_cfg   (r_cfg),
        .o_res   (ctrl_res),
        .o_evt   (stat_evt)
    );

    rls_stats u_stats (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_item  (r_item),
        .i_evt   (stat_evt),
        .o_next  (stat_next)
    );

    always_comb begin
        n_out.send_valid       = ctrl_res.send_valid;
        n_out.send_which       = ctrl_res.send_which;
        n_out.link_status      = ctrl_res.link_status;
        n_out.timeout_count    = stat_next.timeout_count;
        n_out.checksum_count   = stat_next.checksum_count;
        n_out.bad_frame_count  = stat_next.bad_frame_count;
        n_out.overflow_count   = stat_next.overflow_count;
        n_out.card_events      = stat_next.card_events;
        n_out.latest_card_kind = stat_next.latest_card_kind;
        n_out.latest_card_id   = stat_next.latest_card_id;
        n_out.latest_card_tick = stat_next.latest_card_tick;
        n_out.latest_rx_tick   = stat_next.latest_rx_tick;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule
`default_nettype wire
